>>> rtl/core/sorted_key_table_defines.svh
// Assertion macros for the sorted key table.
// No dependencies; included by modules that carry concurrent checks.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define SKT_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("sorted_key_table: same-cycle check failed");

// Next-cycle implication check.
`define SKT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("sorted_key_table: next-cycle check failed");

`else

`define SKT_ASSERT_NOW(label, clk, rst_n, pre, post)
`define SKT_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> rtl/core/sktab_pkg.sv
// Shared types for the sorted key table: operation codes, status codes
// and sequencer states. No dependencies.
package sktab_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_FIND   = 3'd1,
        OP_GET    = 3'd2,
        OP_DELETE = 3'd3,
        OP_POP    = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_CMP   = 6'b000100,
        S_INS   = 6'b001000,
        S_DEL   = 6'b010000,
        S_RDOUT = 6'b100000
    } t_state;

endpackage

>>> rtl/core/sorted_key_table.sv
// Sorted key table: ordered key store in one synchronous RAM with a sequencer
// for binary search, insert/delete shifting, get, pop and clear.
// Depends on sktab_pkg and sorted_key_table_defines.svh.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------------------
//  command   | start in, busy out            | i_operation, i_key, i_position,
//            | taken when start && !busy     | i_count
//  result    | o_done strobe, one cycle      | o_status, o_result_position,
//            | no back-pressure              | o_key_out, o_fill_count
//
// Work per item, from acceptance to the o_done strobe:
//   clear, unused codes and every rejected item: no RAM access.
//   get, pop: one RAM read, registered data.
//   find: a binary search, one registered RAM read per probe.
//   insert: the find search, then every entry from the slot upward moves up one.
//   delete: every entry above the deleted run moves down by the count.
//   The single RAM port pair sets the pace: one entry moves per cycle while shifting.
// Reset clears the control registers only; RAM contents are not cleared and never
// read past the fill count. Results cannot be stalled; busy stays high until
// the cycle that shows the result, and a new item may be taken in that cycle.
module sorted_key_table
    import sktab_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_operation,
    input  logic [KEY_WIDTH-1:0]              i_key,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_position,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]  i_count,
    output logic                              o_done,
    output logic [2:0]                        o_status,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_result_position,
    output logic [KEY_WIDTH-1:0]              o_key_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  o_fill_count
);

`include "sorted_key_table_defines.svh"

    localparam int AW = $clog2(TABLE_DEPTH);      // entry index
    localparam int CW = $clog2(TABLE_DEPTH + 1);  // fill count, 0..TABLE_DEPTH

    // key RAM: one write and one registered read per cycle
    logic [KEY_WIDTH-1:0] r_key_store [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;

    // control state
    t_state r_state, n_state;
    logic [CW-1:0] r_total, n_total;

    // search window [lo, hx) with hx = hi + 1, current probe
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hx, n_hx;
    logic [AW-1:0]        r_mid, n_mid;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_is_ins, n_is_ins;

    // shift engine: entries left to move, read index, pending write
    logic [AW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [CW-1:0] r_dcnt, n_dcnt;

    // result register
    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic [AW-1:0]        r_rpos, n_rpos;
    logic [KEY_WIDTH-1:0] r_kout, n_kout;

    // combinational helpers
    logic [CW:0]   probe_sum;
    logic [AW-1:0] probe_mid;
    logic [CW:0]   del_end;
    logic          ins_go;
    logic [AW-1:0] ins_slot;

    assign probe_sum = (CW+1)'(r_lo) + (CW+1)'(r_hx) - (CW+1)'(1);
    assign probe_mid = AW'(probe_sum >> 1);
    assign del_end   = (CW+1)'(i_position) + (CW+1)'(i_count);

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_lo     = r_lo;
        n_hx     = r_hx;
        n_mid    = r_mid;
        n_key    = r_key;
        n_is_ins = r_is_ins;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_waddr  = r_waddr;
        n_dcnt   = r_dcnt;
        n_done   = 1'b0;
        n_status = ST_OK;
        n_rpos   = '0;
        n_kout   = '0;
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = r_rdata;
        mem_raddr = r_idx;
        ins_go    = 1'b0;
        ins_slot  = r_mid;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_operation))
                        OP_INSERT, OP_FIND: begin
                            if ((t_op'(i_operation) == OP_INSERT) &&
                                (r_total >= CW'(TABLE_DEPTH))) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_key    = i_key;
                                n_is_ins = (t_op'(i_operation) == OP_INSERT);
                                n_lo     = '0;
                                n_hx     = r_total;
                                n_state  = S_PROBE;
                            end
                        end
                        OP_GET: begin
                            if (CW'(i_position) >= r_total) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_POS;
                            end else begin
                                mem_raddr = i_position;
                                n_state   = S_RDOUT;
                            end
                        end
                        OP_DELETE: begin
                            if ((CW'(i_position) >= r_total) ||
                                (del_end > (CW+1)'(r_total))) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_POS;
                            end else begin
                                n_cnt   = CW'((CW+1)'(r_total) - del_end);
                                n_idx   = AW'(del_end);
                                n_dcnt  = i_count;
                                n_pend  = 1'b0;
                                n_state = S_DEL;
                            end
                        end
                        OP_POP: begin
                            if (r_total == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_raddr = AW'(r_total - CW'(1));
                                n_total   = r_total - CW'(1);
                                n_state   = S_RDOUT;
                            end
                        end
                        OP_CLEAR: begin
                            n_total = '0;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_PROBE: begin
                if (r_lo < r_hx) begin
                    mem_raddr = probe_mid;
                    n_mid     = probe_mid;
                    n_state   = S_CMP;
                end else if (r_is_ins) begin
                    ins_go   = 1'b1;
                    ins_slot = AW'(r_lo);
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end
            end

            S_CMP: begin
                if (r_rdata == r_key) begin
                    if (r_is_ins) begin
                        ins_go   = 1'b1;
                        ins_slot = r_mid;
                    end else begin
                        n_done  = 1'b1;
                        n_rpos  = r_mid;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_rdata < r_key) begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end else begin
                        n_hx = CW'(r_mid);
                    end
                    n_state = S_PROBE;
                end
            end

            // move entries up one slot, highest first; reads stay below writes
            S_INS: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_waddr;
                    mem_wdata = r_rdata;
                end
                if (r_cnt != '0) begin
                    mem_raddr = r_idx;
                    n_pend    = 1'b1;
                    n_waddr   = r_idx + AW'(1);
                    n_idx     = r_idx - AW'(1);
                    n_cnt     = r_cnt - CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_slot;
                        mem_wdata = r_key;
                        n_total   = r_total + CW'(1);
                        n_done    = 1'b1;
                        n_rpos    = r_slot;
                        n_state   = S_IDLE;
                    end
                end
            end

            // move entries down by the deleted count, lowest first
            S_DEL: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_waddr;
                    mem_wdata = r_rdata;
                end
                if (r_cnt != '0) begin
                    mem_raddr = r_idx;
                    n_pend    = 1'b1;
                    n_waddr   = r_idx - r_dcnt[AW-1:0];
                    n_idx     = r_idx + AW'(1);
                    n_cnt     = r_cnt - CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_total = r_total - r_dcnt;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            S_RDOUT: begin
                n_done  = 1'b1;
                n_kout  = r_rdata;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ins_go) begin
            n_slot  = ins_slot;
            n_cnt   = r_total - CW'(ins_slot);
            n_idx   = AW'(r_total - CW'(1));
            n_pend  = 1'b0;
            n_state = S_INS;
        end
    end

    // key RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_store[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_key_store[mem_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hx     <= n_hx;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_is_ins <= n_is_ins;
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_waddr  <= n_waddr;
        r_dcnt   <= n_dcnt;
        r_status <= n_status;
        r_rpos   <= n_rpos;
        r_kout   <= n_kout;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_result_position = r_rpos;
    assign o_key_out         = r_kout;
    assign o_fill_count      = r_total;

    // fill count never passes the table depth
    `SKT_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_total <= CW'(TABLE_DEPTH))
    // every accepted item either answers next cycle or keeps the block busy
    `SKT_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, o_done || busy)
    // a full report only comes from a full table
    `SKT_ASSERT_NOW(a_full_report, i_clk, i_rst_n, o_done && (o_status == ST_FULL), r_total == CW'(TABLE_DEPTH))
    // insert shift never moves more entries than the table holds
    `SKT_ASSERT_NOW(a_shift_bound, i_clk, i_rst_n, r_state == S_INS, r_cnt <= r_total)

endmodule
